>>> sv/dlft_pkg.sv
// Shared types and constants for the delimited line field tokenizer.
// Used by dlft_step, dlft_burst, the top level and its checker; depends on nothing.
package dlft_pkg;

  localparam int MAX_FIELD_INDEX = 255;
  localparam int MAX_RESULTS     = 5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SEPARATOR  = 2'd0;
  localparam logic [1:0] CFG_PARSE_STR  = 2'd1;
  localparam logic [1:0] CFG_KEEP_QUOTE = 2'd2;
  localparam logic [1:0] CFG_FIRST_HDR  = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_LINE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       is_row_header;
    logic [7:0] field_index;
  } result_t;

  typedef struct packed {
    logic [7:0] separator_char;
    logic       parse_strings;
    logic       keep_quotes;
    logic       first_column_header;
  } cfg_t;

  typedef struct packed {
    logic       in_quote;
    logic       after_backslash;
    logic       word_pending;
    logic       row_header_pending;
    logic [7:0] field_counter;
  } line_state_t;

endpackage

>>> sv/dlft_step.sv
// Combinational step of the tokenizer: one byte and the line state in,
// the list of results and the next line state out. Depends on dlft_pkg.
module dlft_step (
  input  dlft_pkg::cfg_t                                   cfg,
  input  dlft_pkg::line_state_t                            st,
  input  logic [7:0]                                       text_byte,
  input  logic                                             line_end,
  output dlft_pkg::line_state_t                            st_next,
  output dlft_pkg::result_t [dlft_pkg::MAX_RESULTS-1:0]    res,
  output logic [2:0]                                       res_count
);

  localparam int NCAND = 7;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b >= 8'h09 && b <= 8'h0D) || b == 8'h20 || b == 8'h85 || b == 8'hA0;
  endfunction

  dlft_pkg::result_t [NCAND-1:0] cand;
  logic [NCAND-1:0]              cand_en;
  logic                          is_sep;
  logic                          iq_n;
  logic                          ab_n;
  logic                          wp_n;
  logic                          hdr;
  logic                          field_done;
  logic [7:0]                    body_byte;
  logic [7:0]                    esc_byte;
  dlft_pkg::result_t             field_res;

  always_comb begin
    is_sep = (cfg.separator_char == 8'd0) ? is_ws(text_byte)
                                          : (text_byte == cfg.separator_char);
    hdr = cfg.first_column_header && st.row_header_pending;
    field_res.kind          = dlft_pkg::KIND_FIELD;
    field_res.out_byte      = 8'd0;
    field_res.is_row_header = hdr;
    field_res.field_index   = hdr ? 8'd0 : st.field_counter;

    if (text_byte == dlft_pkg::CH_LOWER_T) begin
      esc_byte = dlft_pkg::CH_TAB;
    end else if (text_byte == dlft_pkg::CH_LOWER_N) begin
      esc_byte = dlft_pkg::CH_NEWLINE;
    end else begin
      esc_byte = dlft_pkg::CH_QUESTION;
    end

    // Candidates in emission order: discard, body byte, body field,
    // pending backslash at line end, closing quote at line end, field at
    // line end, line complete.
    cand_en   = '0;
    body_byte = text_byte;
    iq_n      = st.in_quote;
    ab_n      = st.after_backslash;
    wp_n      = st.word_pending;

    if (st.in_quote) begin
      if (st.after_backslash) begin
        cand_en[1] = 1'b1;
        body_byte  = esc_byte;
        ab_n       = 1'b0;
      end else if (text_byte == dlft_pkg::CH_BACKSLASH) begin
        ab_n = 1'b1;
      end else if (text_byte == dlft_pkg::CH_QUOTE) begin
        cand_en[1] = cfg.keep_quotes;
        cand_en[2] = 1'b1;
        iq_n       = 1'b0;
      end else begin
        cand_en[1] = 1'b1;
      end
    end else if (cfg.parse_strings && text_byte == dlft_pkg::CH_QUOTE) begin
      cand_en[0] = st.word_pending;
      cand_en[1] = cfg.keep_quotes;
      wp_n       = 1'b0;
      iq_n       = 1'b1;
      ab_n       = 1'b0;
    end else if (is_sep) begin
      cand_en[2] = st.word_pending;
      wp_n       = 1'b0;
    end else begin
      cand_en[1] = 1'b1;
      wp_n       = 1'b1;
    end

    if (line_end) begin
      if (iq_n) begin
        cand_en[3] = ab_n;
        cand_en[4] = cfg.keep_quotes;
        cand_en[5] = 1'b1;
      end else begin
        cand_en[5] = wp_n;
      end
      cand_en[6] = 1'b1;
    end

    cand[0] = '{kind: dlft_pkg::KIND_DISCARD, out_byte: 8'd0,
                is_row_header: 1'b0, field_index: 8'd0};
    cand[1] = '{kind: dlft_pkg::KIND_BYTE, out_byte: body_byte,
                is_row_header: 1'b0, field_index: 8'd0};
    cand[2] = field_res;
    cand[3] = '{kind: dlft_pkg::KIND_BYTE, out_byte: dlft_pkg::CH_BACKSLASH,
                is_row_header: 1'b0, field_index: 8'd0};
    cand[4] = '{kind: dlft_pkg::KIND_BYTE, out_byte: dlft_pkg::CH_QUOTE,
                is_row_header: 1'b0, field_index: 8'd0};
    cand[5] = field_res;
    cand[6] = '{kind: dlft_pkg::KIND_LINE, out_byte: 8'd0,
                is_row_header: 1'b0, field_index: 8'd0};

    // Pack the enabled candidates into consecutive slots.
    res       = '0;
    res_count = 3'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && res_count < 3'(dlft_pkg::MAX_RESULTS)) begin
        res[res_count] = cand[i];
        res_count      = res_count + 3'd1;
      end
    end

    // At most one field completes per byte.
    field_done = cand_en[2] || cand_en[5];
    st_next.in_quote           = iq_n;
    st_next.after_backslash    = ab_n;
    st_next.word_pending       = wp_n;
    st_next.row_header_pending = st.row_header_pending && !field_done;
    st_next.field_counter      = st.field_counter;
    if (field_done && !hdr && st.field_counter < 8'(dlft_pkg::MAX_FIELD_INDEX)) begin
      st_next.field_counter = st.field_counter + 8'd1;
    end
    if (line_end) begin
      st_next.in_quote           = 1'b0;
      st_next.after_backslash    = 1'b0;
      st_next.word_pending       = 1'b0;
      st_next.row_header_pending = 1'b1;
      st_next.field_counter      = 8'd0;
    end
  end

endmodule

>>> sv/dlft_burst.sv
// Result register of the tokenizer: holds the results of one byte and hands
// them out one beat at a time. Depends on dlft_pkg.
module dlft_burst (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  dlft_pkg::result_t [dlft_pkg::MAX_RESULTS-1:0] load_res,
  input  logic [2:0]                                    load_count,
  output logic                                          free,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output dlft_pkg::result_t                             out_res,
  output logic                                          out_last
);

  dlft_pkg::result_t [dlft_pkg::MAX_RESULTS-1:0] res;
  logic [2:0] count;
  logic [2:0] pos;
  logic       valid;

  assign out_valid = valid;
  assign out_res   = res[pos];
  assign out_last  = (pos == count - 3'd1);
  assign free      = !valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= 3'd0;
    end else if (load) begin
      valid <= 1'b1;
      pos   <= 3'd0;
    end else if (valid && out_ready) begin
      if (out_last) begin
        valid <= 1'b0;
      end
      pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res   <= load_res;
      count <= load_count;
    end
  end

endmodule

>>> sv/delimited_line_field_tokenizer.sv
// Top level of the delimited line field tokenizer.
// Instantiates dlft_step and dlft_burst; depends on dlft_pkg.
//
// Usage: the input channel (in_valid/in_ready) carries one beat per text
// byte, with line_end set on the last byte of a line. The output channel
// (out_valid/out_ready) carries one beat per result: a field byte, a
// field-complete mark with its column index and row-header flag, a discard
// mark for partial text dropped by an opening quote, or a line-complete mark.
// last_of_item is set on the final result beat caused by a given input byte.
// A byte may cause no result at all, or up to five.
//
// Flow: an accepted byte sits in the input register, is tokenized into the
// result register once that register is free, and its first result beat
// is then shown from the result register.
// Throughput: one byte per cycle while each byte causes at most one result
// and out_ready stays high. A byte with n results occupies the result
// register until its n beats go out; the input register holds the next byte.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and in_ready drops; nothing is lost.
// Reset (synchronous, active high) empties both registers, returns the line
// state to the start of a line and loads the register defaults: whitespace
// separation, string parsing on, quote marks dropped, no row header.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and are meant to be issued only while the block is idle.
module delimited_line_field_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       is_row_header,
  output logic [7:0] field_index,
  output logic       last_of_item
);

  dlft_pkg::cfg_t        cfg;
  dlft_pkg::line_state_t st;
  dlft_pkg::line_state_t st_next;

  // Input register.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_end;

  dlft_pkg::result_t [dlft_pkg::MAX_RESULTS-1:0] step_res;
  logic [2:0]        step_count;
  logic              buf_free;
  logic              step_go;
  dlft_pkg::result_t cur;

  // The held byte is tokenized whenever the result register is free, or
  // becomes free at this edge.
  assign step_go  = hold_valid && buf_free;
  assign in_ready = !hold_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator_char      <= 8'd0;
      cfg.parse_strings       <= 1'b1;
      cfg.keep_quotes         <= 1'b0;
      cfg.first_column_header <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dlft_pkg::CFG_SEPARATOR:  cfg.separator_char      <= cfg_data;
        dlft_pkg::CFG_PARSE_STR:  cfg.parse_strings       <= cfg_data[0];
        dlft_pkg::CFG_KEEP_QUOTE: cfg.keep_quotes         <= cfg_data[0];
        dlft_pkg::CFG_FIRST_HDR:  cfg.first_column_header <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (step_go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= text_byte;
      hold_end  <= line_end;
    end
  end

  // Line state advances once per tokenized byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.in_quote           <= 1'b0;
      st.after_backslash    <= 1'b0;
      st.word_pending       <= 1'b0;
      st.row_header_pending <= 1'b1;
      st.field_counter      <= 8'd0;
    end else if (step_go) begin
      st <= st_next;
    end
  end

  dlft_step u_step (
    .cfg       (cfg),
    .st        (st),
    .text_byte (hold_byte),
    .line_end  (hold_end),
    .st_next   (st_next),
    .res       (step_res),
    .res_count (step_count)
  );

  // Silent bytes are consumed without touching the result register.
  dlft_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (step_go && step_count != 3'd0),
    .load_res   (step_res),
    .load_count (step_count),
    .free       (buf_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (cur),
    .out_last   (last_of_item)
  );

  assign kind          = cur.kind;
  assign out_byte      = cur.out_byte;
  assign is_row_header = cur.is_row_header;
  assign field_index   = cur.field_index;

endmodule

>>> sv/dlft_checker.sv
// Port-level checker for the delimited line field tokenizer, with its bind.
// Depends on dlft_pkg.
module dlft_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic       is_row_header,
  input logic [7:0] field_index,
  input logic       last_of_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(field_index) && $stable(is_row_header) && $stable(last_of_item))
    else $error("result beat changed while stalled");

  a_field_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != dlft_pkg::KIND_FIELD |-> field_index == 8'd0 && !is_row_header)
    else $error("index or header flag on a non-field result");

  a_byte_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != dlft_pkg::KIND_BYTE |-> out_byte == 8'd0)
    else $error("byte value on a non-byte result");

  a_line_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == dlft_pkg::KIND_LINE |-> last_of_item)
    else $error("line-complete result not last of its byte");

  a_hdr_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_row_header |-> field_index == 8'd0)
    else $error("row header with nonzero index");

endmodule

bind delimited_line_field_tokenizer dlft_checker u_dlft_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .out_byte      (out_byte),
  .is_row_header (is_row_header),
  .field_index   (field_index),
  .last_of_item  (last_of_item)
);
